>>> rtl/canonical_huffman_table_decoder_top_assert.svh
// Assertion macros used by the decoder back end
`ifndef CANONICAL_HUFFMAN_TABLE_DECODER_TOP_ASSERT_SVH
`define CANONICAL_HUFFMAN_TABLE_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CHTD_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define CHTD_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define CHTD_ASSERT(name, prop)
`define CHTD_ASSERT_NEXT(name, pre, post)
`endif
`endif

>>> rtl/chtd_pkg.sv
// Types and constants of the canonical Huffman table decoder
package chtd_pkg;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_TABLE = 2'd1;
	localparam logic [1:0] MODE_DATA  = 2'd2;
	localparam logic [1:0] MODE_END   = 2'd3;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_LEN   = 3'd1;
	localparam logic [2:0] ST_OVF   = 3'd2;
	localparam logic [2:0] ST_CODE  = 3'd3;
	localparam logic [2:0] ST_EARLY = 3'd4;

	localparam logic [4:0] MAX_LEN_RESET = 5'd12;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  symbol_value;
		logic [4:0]  code_length;
		logic [7:0]  data_byte;
		logic [23:0] symbol_count;
	} in_t;

	typedef struct packed {
		logic [7:0] decoded_symbol;
		logic       symbol_valid;
		logic       run_last;
		logic       block_done;
		logic [2:0] status;
	} out_t;

	// classified request held in the queue
	typedef struct packed {
		logic        is_start;
		logic        is_table;
		logic        is_data;
		logic [7:0]  symbol_value;
		logic [4:0]  code_length;
		logic [7:0]  data_byte;
		logic [23:0] symbol_count;
	} req_t;

endpackage

>>> rtl/canonical_huffman_table_decoder_top.sv
// Sequencing: an accepted request is queued, and a start, error or rejected item answers through the
// output register when it leaves the queue. A table entry of length L answers at once, then
// writes 2^(M-L) slots, one per cycle, before the next request leaves the queue.
// A data or end item is decoded one symbol at a time (table read, then check and shift).
// Reset clears all control state; table contents are undefined until filled.
// Top level of the canonical Huffman flat table decoder
module canonical_huffman_table_decoder_top #(
	parameter int MAX_CODE_LEN = 12,
	parameter int COUNT_BITS   = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [4:0]     cfg_wdata,
	input  logic           req_valid,
	output logic           req_ready,
	input  chtd_pkg::in_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output chtd_pkg::out_t rsp_data
);

	logic           q_valid;
	logic           q_pop;
	chtd_pkg::req_t q_data;

	// accept and queue requests
	chtd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop)
	);

	// carry out requests
	chtd_back #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.COUNT_BITS   (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

>>> rtl/chtd_front.sv
// Front end: accepts requests, classifies them and queues them for the back end
module chtd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  chtd_pkg::in_t req_data,
	output logic          q_valid,
	output chtd_pkg::req_t q_data,
	input  logic          q_pop
);

	chtd_pkg::req_t slot_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;
	chtd_pkg::req_t cls;

	// classify the request by mode
	always_comb begin
		cls.is_start     = (req_data.mode == chtd_pkg::MODE_START);
		cls.is_table     = (req_data.mode == chtd_pkg::MODE_TABLE);
		cls.is_data      = (req_data.mode == chtd_pkg::MODE_DATA);
		cls.symbol_value = req_data.symbol_value;
		cls.code_length  = req_data.code_length;
		cls.data_byte    = req_data.data_byte;
		cls.symbol_count = req_data.symbol_count;
	end

	assign req_ready = (cnt_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_data    = slot_q[rp_q];

	// hold queued payloads
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= cls;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

>>> rtl/chtd_back.sv
// Back end: table fill, bit buffer and symbol decode with output register
`include "canonical_huffman_table_decoder_top_assert.svh"
module chtd_back #(
	parameter int MAX_CODE_LEN = 12,
	parameter int COUNT_BITS   = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_wdata,
	input  logic            q_valid,
	input  chtd_pkg::req_t  q_data,
	output logic            q_pop,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output chtd_pkg::out_t  rsp_data
);

	localparam int FPW   = MAX_CODE_LEN + 1;
	localparam int DEPTH = 1 << MAX_CODE_LEN;
	localparam int MW    = MAX_CODE_LEN;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FILL = 3'd1;
	localparam logic [2:0] S_LOOP = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CK   = 3'd4;

	logic [12:0]           tbl_mem [DEPTH];

	logic [4:0]            maxlen_q;
	logic [2:0]            state_q, state_d;
	logic [FPW-1:0]        fill_q, fill_d;
	logic [4:0]            prev_q, prev_d;
	logic [31:0]           buf_q, buf_d;
	logic [5:0]            nbits_q, nbits_d;
	logic [COUNT_BITS-1:0] left_q, left_d;
	logic [2:0]            err_q, err_d;
	logic                  end_q, end_d;
	logic [MW-1:0]         wr_ptr_q, wr_ptr_d;
	logic [FPW-1:0]        wr_left_q, wr_left_d;
	logic [7:0]            wr_sym_q, wr_sym_d;
	logic [4:0]            wr_len_q, wr_len_d;
	logic [7:0]            rd_sym_q;
	logic [4:0]            rd_len_q;
	chtd_pkg::out_t        out_q, emit_d;
	logic                  out_valid_q;
	logic                  emit, can_emit, mem_we, mem_re;

	logic [4:0]            m;
	logic [MW-1:0]         idx;
	logic [FPW-1:0]        span, cap;
	logic [FPW:0]          fill_sum;
	logic [31:0]           sh_buf;
	logic [5:0]            sh_n;
	logic [COUNT_BITS-1:0] left_n;
	logic                  cont;

	// clamp the maximum code length
	always_comb begin
		priority if (maxlen_q == 5'd0) begin
			m = 5'd1;
		end else if (maxlen_q > 5'(MAX_CODE_LEN)) begin
			m = 5'(MAX_CODE_LEN);
		end else begin
			m = maxlen_q;
		end
	end

	assign idx      = MW'(buf_q >> (6'd32 - {1'b0, m}));
	assign span     = FPW'(1) << (m - q_data.code_length);
	assign cap      = FPW'(1) << m;
	assign fill_sum = {1'b0, fill_q} + {1'b0, span};
	assign sh_buf   = buf_q << rd_len_q;
	assign sh_n     = nbits_q - {1'b0, rd_len_q};
	assign left_n   = left_q - COUNT_BITS'(1);
	assign cont     = end_q ? (left_n != '0) : ((left_n != '0) && (sh_n >= {1'b0, m}));
	assign can_emit = !out_valid_q || rsp_ready;

	// sequence one request at a time
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		prev_d    = prev_q;
		buf_d     = buf_q;
		nbits_d   = nbits_q;
		left_d    = left_q;
		err_d     = err_q;
		end_d     = end_q;
		wr_ptr_d  = wr_ptr_q;
		wr_left_d = wr_left_q;
		wr_sym_d  = wr_sym_q;
		wr_len_d  = wr_len_q;
		emit      = 1'b0;
		emit_d    = '0;
		emit_d.block_done = (left_q == '0);
		emit_d.run_last   = 1'b1;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					priority if (q_data.is_start) begin
						if (can_emit) begin
							q_pop   = 1'b1;
							fill_d  = '0;
							prev_d  = '0;
							buf_d   = '0;
							nbits_d = '0;
							err_d   = chtd_pkg::ST_OK;
							left_d  = COUNT_BITS'(q_data.symbol_count);
							emit    = 1'b1;
							emit_d.block_done = (left_d == '0);
						end
					end else if (err_q != chtd_pkg::ST_OK) begin
						if (can_emit) begin
							q_pop = 1'b1;
							emit  = 1'b1;
							emit_d.status = err_q;
						end
					end else if (q_data.is_table) begin
						if (can_emit) begin
							q_pop = 1'b1;
							emit  = 1'b1;
							priority if (q_data.code_length == 5'd0 || q_data.code_length > m
								|| q_data.code_length < prev_q) begin
								emit_d.status = chtd_pkg::ST_LEN;
								err_d         = chtd_pkg::ST_LEN;
							end else if (fill_sum > {1'b0, cap}) begin
								emit_d.status = chtd_pkg::ST_OVF;
								err_d         = chtd_pkg::ST_OVF;
							end else begin
								fill_d    = fill_sum[FPW-1:0];
								prev_d    = q_data.code_length;
								wr_ptr_d  = fill_q[MW-1:0];
								wr_left_d = span;
								wr_sym_d  = q_data.symbol_value;
								wr_len_d  = q_data.code_length;
								state_d   = S_FILL;
							end
						end
					end else if (q_data.is_data) begin
						q_pop = 1'b1;
						end_d = 1'b0;
						if (left_q != '0 && nbits_q <= 6'd24) begin
							buf_d   = buf_q | (32'(q_data.data_byte) << (5'd24 - nbits_q[4:0]));
							nbits_d = nbits_q + 6'd8;
						end
						state_d = S_LOOP;
					end else begin
						q_pop   = 1'b1;
						end_d   = 1'b1;
						state_d = S_LOOP;
					end
				end
			end
			S_FILL: begin
				mem_we    = 1'b1;
				wr_ptr_d  = wr_ptr_q + MW'(1);
				wr_left_d = wr_left_q - FPW'(1);
				if (wr_left_q == FPW'(1)) begin
					state_d = S_IDLE;
				end
			end
			S_LOOP: begin
				if (end_q) begin
					priority if (left_q == '0) begin
						if (can_emit) begin
							emit    = 1'b1;
							buf_d   = '0;
							nbits_d = '0;
							state_d = S_IDLE;
						end
					end else if (nbits_q == 6'd0) begin
						if (can_emit) begin
							emit          = 1'b1;
							emit_d.status = chtd_pkg::ST_EARLY;
							err_d         = chtd_pkg::ST_EARLY;
							buf_d         = '0;
							state_d       = S_IDLE;
						end
					end else begin
						state_d = S_RD;
					end
				end else if (left_q != '0 && nbits_q >= {1'b0, m}) begin
					state_d = S_RD;
				end else if (can_emit) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				// end of stream with symbols left but no real bits
				priority if (end_q && nbits_q == 6'd0) begin
					if (can_emit) begin
						emit          = 1'b1;
						emit_d.status = chtd_pkg::ST_EARLY;
						err_d         = chtd_pkg::ST_EARLY;
						buf_d         = '0;
						state_d       = S_IDLE;
					end
				end else if ({1'b0, idx} >= fill_q) begin
					if (can_emit) begin
						emit          = 1'b1;
						emit_d.status = chtd_pkg::ST_CODE;
						err_d         = chtd_pkg::ST_CODE;
						if (end_q) begin
							buf_d   = '0;
							nbits_d = '0;
						end
						state_d = S_IDLE;
					end
				end else begin
					mem_re  = 1'b1;
					state_d = S_CK;
				end
			end
			S_CK: begin
				if (can_emit) begin
					emit = 1'b1;
					priority if (rd_len_q == 5'd0 || rd_len_q > m) begin
						emit_d.status = chtd_pkg::ST_CODE;
						err_d         = chtd_pkg::ST_CODE;
						state_d       = S_IDLE;
					end else if (end_q && {1'b0, rd_len_q} > nbits_q) begin
						emit_d.status = chtd_pkg::ST_EARLY;
						err_d         = chtd_pkg::ST_EARLY;
						state_d       = S_IDLE;
					end else begin
						buf_d   = sh_buf;
						nbits_d = sh_n;
						left_d  = left_n;
						emit_d.decoded_symbol = rd_sym_q;
						emit_d.symbol_valid   = 1'b1;
						emit_d.block_done     = (left_n == '0);
						emit_d.run_last       = !cont;
						state_d = cont ? S_RD : S_IDLE;
					end
					if (end_q && state_d == S_IDLE) begin
						buf_d   = '0;
						nbits_d = '0;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// write and read the lookup table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[wr_ptr_q] <= {wr_sym_q, wr_len_q};
		end
		if (mem_re) begin
			{rd_sym_q, rd_len_q} <= tbl_mem[idx];
		end
	end

	// hold the write request of a fill and register the output
	always_ff @(posedge clk) begin
		wr_ptr_d_hold: begin
			wr_sym_q <= wr_sym_d;
			wr_len_q <= wr_len_d;
		end
		if (emit) begin
			out_q <= emit_d;
		end
	end

	// advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxlen_q    <= chtd_pkg::MAX_LEN_RESET;
			state_q     <= S_IDLE;
			fill_q      <= '0;
			prev_q      <= '0;
			buf_q       <= '0;
			nbits_q     <= '0;
			left_q      <= '0;
			err_q       <= chtd_pkg::ST_OK;
			end_q       <= 1'b0;
			wr_ptr_q    <= '0;
			wr_left_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				maxlen_q <= cfg_wdata;
			end
			state_q   <= state_d;
			fill_q    <= fill_d;
			prev_q    <= prev_d;
			buf_q     <= buf_d;
			nbits_q   <= nbits_d;
			left_q    <= left_d;
			err_q     <= err_d;
			end_q     <= end_d;
			wr_ptr_q  <= wr_ptr_d;
			wr_left_q <= wr_left_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	`CHTD_ASSERT(a_fill_nonempty, state_q != S_FILL || wr_left_q != '0)
	`CHTD_ASSERT(a_sym_ok, !(out_valid_q && out_q.symbol_valid) || out_q.status == chtd_pkg::ST_OK)
	`CHTD_ASSERT_NEXT(a_err_sticky, emit && emit_d.status != chtd_pkg::ST_OK, err_q != chtd_pkg::ST_OK)
	`CHTD_ASSERT(a_pop_idle, !q_pop || state_q == S_IDLE)

endmodule

>>> tb/sv/tb_canonical_huffman_table_decoder_top.sv
// Self-checking testbench for the canonical Huffman flat table decoder
module tb_canonical_huffman_table_decoder_top;

	localparam int TBL_DEPTH   = 4096;
	localparam int IDLE_CYCLES = 5000;
	localparam int WDOG_LIMIT  = 30000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_wdata;
	logic req_valid;
	logic req_ready;
	chtd_pkg::in_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	chtd_pkg::out_t rsp_data;

	canonical_huffman_table_decoder_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
	);

	// decoder shadow state
	logic [4:0] max_len_reg;
	logic [7:0] tbl_sym [TBL_DEPTH];
	logic [4:0] tbl_len [TBL_DEPTH];
	int unsigned fill_ptr, prev_len, bits_held, syms_left;
	logic [2:0] sticky_err;
	logic [31:0] bit_buf;

	chtd_pkg::out_t expected_syms[$];
	int mismatches;
	int items_sent, results_seen, symbols_seen;
	int rx_hold;
	bit no_gaps;
	int wdog = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned code_width();
		if (max_len_reg < 5'd1) return 1;
		if (max_len_reg > 5'd12) return 12;
		return 32'(max_len_reg);
	endfunction

	function automatic void push_result(logic [7:0] sym, logic vld, logic [2:0] st);
		chtd_pkg::out_t r;
		r.decoded_symbol = sym;
		r.symbol_valid = vld;
		r.run_last = 1'b0;
		r.block_done = (syms_left == 0);
		r.status = st;
		expected_syms.push_back(r);
	endfunction

	// decode one symbol from the top of the bit buffer, return a status code
	function automatic logic [2:0] decode_symbol(bit at_end);
		int unsigned m, len;
		logic [11:0] idx;
		m = code_width();
		idx = 12'(bit_buf >> (32 - m));
		if (32'(idx) >= fill_ptr) return chtd_pkg::ST_CODE;
		len = 32'(tbl_len[idx]);
		if (len < 1 || len > m) return chtd_pkg::ST_CODE;
		if (at_end && len > bits_held) return chtd_pkg::ST_EARLY;
		bit_buf = bit_buf << len;
		bits_held -= len;
		syms_left--;
		push_result(tbl_sym[idx], 1'b1, chtd_pkg::ST_OK);
		return chtd_pkg::ST_OK;
	endfunction

	// work out the results of one accepted request
	function automatic void predict_request(chtd_pkg::in_t it);
		int unsigned m, span, n0, clen;
		logic [2:0] st;
		logic [11:0] slot;
		m = code_width();
		st = chtd_pkg::ST_OK;
		n0 = expected_syms.size();
		clen = 32'(it.code_length);
		if (it.mode == chtd_pkg::MODE_START) begin
			fill_ptr = 0; prev_len = 0; bit_buf = 0; bits_held = 0;
			sticky_err = chtd_pkg::ST_OK;
			syms_left = 32'(it.symbol_count);
		end else if (sticky_err != chtd_pkg::ST_OK) begin
			st = sticky_err;
		end else if (it.mode == chtd_pkg::MODE_TABLE) begin
			if (clen < 1 || clen > m || clen < prev_len) begin
				st = chtd_pkg::ST_LEN;
			end else begin
				span = 1 << (m - clen);
				if (fill_ptr + span > (1 << m)) begin
					st = chtd_pkg::ST_OVF;
				end else begin
					for (int unsigned i = 0; i < span; i++) begin
						slot = 12'(fill_ptr + i);
						tbl_sym[slot] = it.symbol_value;
						tbl_len[slot] = it.code_length;
					end
					fill_ptr += span;
					prev_len = clen;
				end
			end
		end else if (it.mode == chtd_pkg::MODE_DATA) begin
			if (syms_left != 0 && bits_held <= 24) begin
				bit_buf = bit_buf | ({24'd0, it.data_byte} << (24 - bits_held));
				bits_held += 8;
				while (syms_left != 0 && bits_held >= m && st == chtd_pkg::ST_OK)
					st = decode_symbol(1'b0);
			end
		end else begin
			while (syms_left != 0 && st == chtd_pkg::ST_OK) begin
				if (bits_held == 0) st = chtd_pkg::ST_EARLY;
				else st = decode_symbol(1'b1);
			end
			bit_buf = 0;
			bits_held = 0;
		end
		if (st != chtd_pkg::ST_OK) sticky_err = st;
		if (expected_syms.size() == n0 || st != chtd_pkg::ST_OK) push_result(8'd0, 1'b0, st);
		expected_syms[$].run_last = 1'b1;
	endfunction

	// offer one request, hold it until accepted, then predict
	task automatic send_request(chtd_pkg::in_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_request(it);
		items_sent++;
	endtask

	function automatic chtd_pkg::in_t make_request(logic [1:0] md);
		chtd_pkg::in_t it;
		it.mode = md;
		it.symbol_value = 8'($urandom);
		it.code_length = 5'($urandom);
		it.data_byte = 8'($urandom);
		it.symbol_count = 24'($urandom);
		return it;
	endfunction

	task automatic send_start(int unsigned count);
		chtd_pkg::in_t it;
		it = make_request(chtd_pkg::MODE_START);
		it.symbol_count = 24'(count);
		send_request(it);
	endtask

	task automatic send_entry(logic [7:0] sym, logic [4:0] len);
		chtd_pkg::in_t it;
		it = make_request(chtd_pkg::MODE_TABLE);
		it.symbol_value = sym;
		it.code_length = len;
		send_request(it);
	endtask

	task automatic send_byte(logic [7:0] b);
		chtd_pkg::in_t it;
		it = make_request(chtd_pkg::MODE_DATA);
		it.data_byte = b;
		send_request(it);
	endtask

	// drop valid and wait until the block has answered everything and finished fills
	task automatic drain_and_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_syms.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(logic [4:0] v);
		drain_and_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_len_reg = v;
	endtask

	// one block: start, canonical table (complete or cut short), bytes, optional end, with optional noise
	task automatic run_block(bit complete, bit noisy);
		int unsigned m, rem, len, n, nbytes;
		m = code_width();
		send_start($urandom_range(1, 20));
		rem = 1 << m;
		len = $urandom_range(1, (m < 2) ? m : 2);
		n = 0;
		while (rem != 0) begin
			while ((1 << (m - len)) > rem) len++;
			// lengthen only while few entries of the new length would be needed
			if (n < 5 && len < m && rem <= (2 << (m - len)) && $urandom_range(0, 2) == 0) begin
				len++;
				continue;
			end
			send_entry(8'($urandom), 5'(len));
			rem -= 1 << (m - len);
			n++;
			if (!complete && $urandom_range(0, 3) == 0) break;
		end
		if (noisy) send_request(make_request(2'($urandom_range(0, 3))));
		nbytes = 0;
		while (syms_left != 0 && sticky_err == chtd_pkg::ST_OK && nbytes < 12) begin
			send_byte(8'($urandom));
			nbytes++;
		end
		if ($urandom_range(0, 3) != 0) send_request(make_request(chtd_pkg::MODE_END));
	endtask

	task automatic test_directed();
		send_start(0);
		send_request(make_request(chtd_pkg::MODE_END));
		send_byte(8'hFF);
		send_start(3);
		send_entry(8'hAA, 5'd1);
		send_entry(8'h55, 5'd2);
		send_entry(8'hFF, 5'd12);
		// length smaller than the previous one, then a sticky error answer
		send_entry(8'h01, 5'd1);
		send_byte(8'h00);
		send_start(24'hFFFFFF);
		send_entry(8'h00, 5'd0);
		send_start(1);
		send_entry(8'h00, 5'd13);
		send_start(2);
		send_entry(8'h11, 5'd1);
		send_entry(8'h22, 5'd1);
		// table already full
		send_entry(8'h33, 5'd1);
		send_start(5);
		send_entry(8'h44, 5'd1);
		// one byte with top bit 1 gives fewer bits than the code width, so nothing is decoded
		send_byte(8'hFF);
		send_start(4);
		send_entry(8'h01, 5'd1);
		send_entry(8'h02, 5'd1);
		send_byte(8'hA5);
		send_request(make_request(chtd_pkg::MODE_END));
		send_start(10);
		send_entry(8'h03, 5'd1);
		send_entry(8'h04, 5'd1);
		send_byte(8'h5A);
		// runs out of real bits
		send_request(make_request(chtd_pkg::MODE_END));
	endtask

	task automatic test_register_sweep();
		logic [4:0] vals [6];
		vals = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd12, 5'd2};
		foreach (vals[i]) begin
			write_max_len(vals[i]);
			repeat (3) run_block($urandom_range(0, 3) != 0, 1'b0);
		end
	endtask

	task automatic test_random_blocks(int target);
		while (items_sent < target) begin
			if ($urandom_range(0, 15) == 0) write_max_len(5'($urandom_range(3, 8)));
			no_gaps = ($urandom_range(0, 5) == 0);
			run_block($urandom_range(0, 4) != 0, $urandom_range(0, 5) == 0);
			// pause until every expected result is back
			if ($urandom_range(0, 9) == 0) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (expected_syms.size() != 0) @(posedge clk);
			end
		end
		no_gaps = 0;
	endtask

	task automatic test_backpressure();
		no_gaps = 1;
		rx_hold = 400;
		send_start(200);
		send_entry(8'h10, 5'd1);
		send_entry(8'h20, 5'd1);
		repeat (30) send_byte(8'($urandom));
		send_request(make_request(chtd_pkg::MODE_END));
		no_gaps = 0;
	endtask

	// receiver: random stalls per result, plus a long hold when asked
	initial begin
		int gap;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				rsp_ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!(rsp_valid && rsp_ready) && rx_hold == 0) @(posedge clk);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		chtd_pkg::out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
			if (rsp_data.symbol_valid) symbols_seen++;
			if (expected_syms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", rsp_data);
			end else begin
				want = expected_syms.pop_front();
				if (rsp_data !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, rsp_data);
				end
			end
		end
	end

	// stop when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", wdog);
			$display("[canonical_huffman_table_decoder_top] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req_data = '0;
		max_len_reg = chtd_pkg::MAX_LEN_RESET;
		fill_ptr = 0; prev_len = 0; bit_buf = 0; bits_held = 0;
		syms_left = 0; sticky_err = chtd_pkg::ST_OK;
		mismatches = 0; items_sent = 0; results_seen = 0; symbols_seen = 0;
		rx_hold = 0; no_gaps = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_sweep();
		test_backpressure();
		write_max_len(5'd6);
		test_random_blocks(470);
		write_max_len(5'd12);
		run_block(1'b1, 1'b0);
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_syms.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d decoded symbols",
			items_sent, results_seen, symbols_seen);
		$display("across code widths 1 to 12, all error kinds, and a long output stall");
		if (mismatches == 0) begin
			$display("[canonical_huffman_table_decoder_top] OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[canonical_huffman_table_decoder_top] ERROR");
		end
		$finish;
	end

endmodule
